@@ rtl/pft_pkg.sv @@
// ----------------------------------------------------------------------------
// pft_pkg: shared types and constants for the page frame table
// Table geometry, field widths, request kinds and the token that walks
// down the row of frame cells.
// ----------------------------------------------------------------------------
package pft_pkg;

    localparam int FRAMES    = 64;
    localparam int PID_BITS  = 10;
    localparam int PAGE_BITS = 10;

    // fixed widths of the transaction fields
    localparam int KIND_W     = 2;
    localparam int FIDX_W     = 7;
    localparam int FRAME_W    = 6;
    localparam int OUT_CNT_W  = 7;

    // internal widths that follow the table size
    localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CNT_W = $clog2(FRAMES + 1);
    localparam int CMP_W = (IDX_W > FIDX_W) ? IDX_W : FIDX_W;

    typedef enum logic [KIND_W-1:0] {
        KIND_LOOKUP   = 2'd0,
        KIND_ALLOC    = 2'd1,
        KIND_FREE     = 2'd2,
        KIND_FREE_ALL = 2'd3
    } t_kind;

    // request token handed from cell to cell
    typedef struct packed {
        logic                 active;
        t_kind                kind;
        logic [PID_BITS-1:0]  pid;
        logic [PAGE_BITS-1:0] page;
        logic [FIDX_W-1:0]    idx;
        logic                 done;   // lookup hit or allocation taken
        logic [IDX_W-1:0]     frame;
        logic [CNT_W-1:0]     freed;  // valid entries cleared on the way
    } t_token;

    typedef struct packed {
        logic [FRAME_W-1:0]   frame;
        logic                 ok;
        logic [OUT_CNT_W-1:0] free_frames;
    } t_result;

endpackage

@@ rtl/pft_if.sv @@
// ----------------------------------------------------------------------------
// pft_req_if / pft_rsp_if: request and response channels
// Valid/ready channels; a transaction completes when both are high.
// ----------------------------------------------------------------------------
interface pft_req_if;
    logic                           valid;
    logic                           ready;
    logic [pft_pkg::KIND_W-1:0]     kind;
    logic [pft_pkg::PID_BITS-1:0]   process_id;
    logic [pft_pkg::PAGE_BITS-1:0]  page_number;
    logic [pft_pkg::FIDX_W-1:0]     frame_index;

    modport source (output valid, kind, process_id, page_number, frame_index,
                    input ready);
    modport sink   (input valid, kind, process_id, page_number, frame_index,
                    output ready);
endinterface

interface pft_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [pft_pkg::FRAME_W-1:0]    frame;
    logic                           ok;
    logic [pft_pkg::OUT_CNT_W-1:0]  free_frames;

    modport source (output valid, frame, ok, free_frames, input ready);
    modport sink   (input valid, frame, ok, free_frames, output ready);
endinterface

@@ rtl/pft_cell.sv @@
// ----------------------------------------------------------------------------
// pft_cell: one frame entry of the table
// Holds valid/owner/page for one frame, applies the passing request token
// to its entry and forwards the updated token to the next cell.
// ----------------------------------------------------------------------------
module pft_cell (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [pft_pkg::IDX_W-1:0] i_pos,
    input  pft_pkg::t_token          i_tok,
    output pft_pkg::t_token          o_tok
);
    import pft_pkg::*;

    logic                 r_valid;
    logic                 n_valid;
    logic [PID_BITS-1:0]  r_owner;
    logic [PAGE_BITS-1:0] r_page;
    logic                 wr_en;
    logic                 owner_hit;
    t_token               r_tok;
    t_token               n_tok;

    assign owner_hit = r_valid && (r_owner == i_tok.pid);

    always_comb begin
        n_tok   = i_tok;
        n_valid = r_valid;
        wr_en   = 1'b0;
        if (i_tok.active) begin
            case (i_tok.kind)
                KIND_LOOKUP: begin
                    if (!i_tok.done && owner_hit && (r_page == i_tok.page)) begin
                        n_tok.done  = 1'b1;
                        n_tok.frame = i_pos;
                    end
                end
                KIND_ALLOC: begin
                    // first free cell on the way takes it
                    if (!i_tok.done && !r_valid) begin
                        n_valid     = 1'b1;
                        wr_en       = 1'b1;
                        n_tok.done  = 1'b1;
                        n_tok.frame = i_pos;
                    end
                end
                KIND_FREE: begin
                    if (r_valid && (CMP_W'(i_tok.idx) == CMP_W'(i_pos))) begin
                        n_valid     = 1'b0;
                        n_tok.freed = i_tok.freed + CNT_W'(1);
                    end
                end
                KIND_FREE_ALL: begin
                    if (owner_hit) begin
                        n_valid     = 1'b0;
                        n_tok.freed = i_tok.freed + CNT_W'(1);
                    end
                end
                default: begin
                    n_tok = i_tok;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_tok.active <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_tok   <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_owner <= i_tok.pid;
            r_page  <= i_tok.page;
        end
    end

    assign o_tok = r_tok;

endmodule

@@ rtl/page_frame_table.sv @@
// ----------------------------------------------------------------------------
// page_frame_table: inverted page frame table
// Lookup, allocate, free-one and free-all-of-process over FRAMES entries,
// each result carrying the free frame count after the step.
// ----------------------------------------------------------------------------
// Throughput: one request at a time; a new request is taken only in idle,
//   after the previous token has left the row. The token visits one frame
//   cell per cycle, so the length of the cell row sets the rate.
// A new request may be taken while the previous response still waits.
// Reset (synchronous, active low) marks every frame free; owner and page
//   storage is not cleared, it is only read behind a set valid bit.
// ----------------------------------------------------------------------------
module page_frame_table (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pft_req_if.sink   i_req,
    pft_rsp_if.source o_rsp
);
    import pft_pkg::*;

    // one-hot sequencer: idle -> token in flight -> (optional) result parked
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_HOLD = 3'b100
    } t_state;

    t_state          r_state;
    t_state          n_state;
    logic [CNT_W-1:0] r_free;
    logic [CNT_W-1:0] n_free;
    logic            r_out_valid;
    t_result         r_out;
    t_result         r_hold;
    t_result         res;
    t_token          tok [FRAMES+1];
    t_token          tok_end;
    logic            req_xfer;
    logic            out_slot;
    logic            load_out;
    logic            load_hold;

    assign req_xfer    = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign out_slot    = !r_out_valid || o_rsp.ready;

    // launch token into the head of the row
    always_comb begin
        tok[0].active = req_xfer;
        tok[0].kind   = t_kind'(i_req.kind);
        tok[0].pid    = i_req.process_id;
        tok[0].page   = i_req.page_number;
        tok[0].idx    = i_req.frame_index;
        tok[0].done   = 1'b0;
        tok[0].frame  = '0;
        tok[0].freed  = '0;
    end

    // row of frame cells, cell g holds frame g
    for (genvar g = 0; g < FRAMES; g++) begin : g_cell
        pft_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_pos   (IDX_W'(g)),
            .i_tok   (tok[g]),
            .o_tok   (tok[g+1])
        );
    end

    assign tok_end = tok[FRAMES];

    // result assembly when the token leaves the last cell
    always_comb begin
        n_free = r_free + tok_end.freed;
        if (tok_end.kind == KIND_ALLOC && tok_end.done) begin
            n_free = n_free - CNT_W'(1);
        end
        res.free_frames = OUT_CNT_W'(n_free);
        case (tok_end.kind)
            KIND_LOOKUP,
            KIND_ALLOC:    res.ok = tok_end.done;
            KIND_FREE:     res.ok = (int'(tok_end.idx) < FRAMES);
            KIND_FREE_ALL: res.ok = 1'b1;
            default:       res.ok = 1'b0;
        endcase
        // done is only ever set by lookup/allocate, so frees report zero
        res.frame = tok_end.done ? FRAME_W'(tok_end.frame) : '0;
    end

    always_comb begin
        n_state   = r_state;
        load_out  = 1'b0;
        load_hold = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (req_xfer) n_state = S_RUN;
            end
            S_RUN: begin
                if (tok_end.active) begin
                    if (out_slot) begin
                        load_out = 1'b1;
                        n_state  = S_IDLE;
                    end else begin
                        load_hold = 1'b1;
                        n_state   = S_HOLD;
                    end
                end
            end
            S_HOLD: begin
                if (out_slot) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_free      <= CNT_W'(FRAMES);
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_RUN && tok_end.active) begin
                r_free <= n_free;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_hold) begin
            r_hold <= res;
        end
        if (load_out) begin
            r_out <= (r_state == S_HOLD) ? r_hold : res;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.frame       = r_out.frame;
    assign o_rsp.ok          = r_out.ok;
    assign o_rsp.free_frames = r_out.free_frames;

endmodule

@@ rtl/pft_checker.sv @@
// ----------------------------------------------------------------------------
// pft_checker: port-level checks for the page frame table
// Watches the request and response channels over time.
// ----------------------------------------------------------------------------
module pft_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_req_valid,
    input logic                            i_req_ready,
    input logic                            i_rsp_valid,
    input logic                            i_rsp_ready,
    input logic [pft_pkg::FRAME_W-1:0]     i_rsp_frame,
    input logic                            i_rsp_ok,
    input logic [pft_pkg::OUT_CNT_W-1:0]   i_rsp_free_frames
);

    // response transaction held until taken
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=>
            i_rsp_valid && $stable(i_rsp_frame) && $stable(i_rsp_ok)
            && $stable(i_rsp_free_frames))
        else $error("response dropped or changed while stalled");

    // failed requests report frame zero
    a_fail_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ok |-> i_rsp_frame == '0)
        else $error("frame nonzero on failed request");

    // one request in flight: no back-to-back requests
    a_one_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request taken while another is in flight");

    // a new response only follows a cycle where the request side was busy
    a_rsp_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rsp_valid) |-> $past(!i_req_ready))
        else $error("response appeared without a request in flight");

endmodule

bind page_frame_table pft_checker u_pft_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_req_valid       (i_req.valid),
    .i_req_ready       (i_req.ready),
    .i_rsp_valid       (o_rsp.valid),
    .i_rsp_ready       (o_rsp.ready),
    .i_rsp_frame       (o_rsp.frame),
    .i_rsp_ok          (o_rsp.ok),
    .i_rsp_free_frames (o_rsp.free_frames)
);
